@@ rtl/text_glyph_page_framebuffer_assert.svh @@
// assertion macros used by the framebuffer checker
`ifndef TEXT_GLYPH_PAGE_FRAMEBUFFER_ASSERT_SVH
`define TEXT_GLYPH_PAGE_FRAMEBUFFER_ASSERT_SVH

// consequent checked in the same cycle
`define TGPF_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the next cycle
`define TGPF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/tgpf_pkg.sv @@
// shared types, command codes and font table of the glyph framebuffer
package tgpf_pkg;

    typedef enum logic [2:0] {
        CMD_CLEAR      = 3'd0,
        CMD_PLOT       = 3'd1,
        CMD_SET_CURSOR = 3'd2,
        CMD_DRAW       = 3'd3,
        CMD_READ       = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_DRAW,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       en;
        logic [7:0] mask;
        logic [7:0] data;
    } t_wr_req;

    localparam int         GLYPH_COLS  = 5;
    localparam logic [7:0] GLYPH_FIRST = 8'd32;
    localparam logic [7:0] GLYPH_LAST  = 8'd90;
    localparam logic [7:0] LOWER_FIRST = 8'd97;
    localparam logic [7:0] LOWER_LAST  = 8'd122;
    localparam logic [7:0] CASE_OFFSET = 8'd32;
    localparam logic [7:0] CELL_MASK   = 8'h7F;
    localparam logic [7:0] ADVANCE_X   = 8'd6;
    localparam logic [8:0] ADVANCE_Y   = 9'd9;
    localparam logic [7:0] CURSOR_XMAX = 8'd127;
    localparam logic [8:0] CURSOR_YMAX = 9'd255;
    localparam logic [3:0] DRAW_STEPS  = 4'd10;

    // columns packed left to right, first column in the top byte
    localparam logic [39:0] GLYPH_ROM [0:58] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543
    };

    function automatic logic [7:0] glyph_column(input logic [5:0] idx, input logic [2:0] col);
        logic [39:0] w;
        w = GLYPH_ROM[idx];
        return w[8*(GLYPH_COLS-1-int'(col)) +: 8];
    endfunction

endpackage

@@ rtl/tgpf_ram.sv @@
// generic single write port ram with registered read
module tgpf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ rtl/tgpf_glyph.sv @@
// glyph cell address, mask and pixel data for one draw step
module tgpf_glyph import tgpf_pkg::*; #(
    parameter int SCREEN_WIDTH = 128,
    parameter int SCREEN_HEIGHT = 64,
    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8,
    localparam int AW = $clog2(SCREEN_WIDTH * PAGES)
) (
    input  logic [3:0]    i_step,
    input  logic [6:0]    i_cur_x,
    input  logic [7:0]    i_cur_y,
    input  logic [7:0]    i_code,
    output logic [AW-1:0] o_addr,
    output t_wr_req       o_wr
);

    logic [7:0]  code_f;
    logic        drawable;
    logic [5:0]  idx;
    logic [2:0]  col;
    logic [7:0]  bits;
    logic [7:0]  x;
    logic [5:0]  page;
    logic [15:0] sh_mask;
    logic [15:0] sh_data;
    logic [7:0]  mask8;
    logic        col_ok;
    logic        page_ok;

    always_comb begin
        code_f = (i_code >= LOWER_FIRST && i_code <= LOWER_LAST) ? i_code - CASE_OFFSET
                                                                  : i_code;
        drawable = (code_f >= GLYPH_FIRST) && (code_f <= GLYPH_LAST);
        idx      = drawable ? 6'(code_f - GLYPH_FIRST) : 6'd0;
        col      = i_step[3:1];
        bits     = glyph_column(idx, col) & CELL_MASK;
        x        = {1'b0, i_cur_x} + {5'b0, col};
        page     = {1'b0, i_cur_y[7:3]} + {5'b0, i_step[0]};
        sh_mask  = {8'h00, CELL_MASK} << i_cur_y[2:0];
        sh_data  = {8'h00, bits} << i_cur_y[2:0];
        mask8    = i_step[0] ? sh_mask[15:8] : sh_mask[7:0];
        // rows below the screen bottom
        for (int b = 0; b < 8; b++) begin
            if ({page, 3'(b)} >= 9'(SCREEN_HEIGHT)) begin
                mask8[b] = 1'b0;
            end
        end
        col_ok  = {1'b0, x} < 9'(SCREEN_WIDTH);
        page_ok = page < 6'(PAGES);
        o_wr.en   = drawable && col_ok && page_ok && (mask8 != 8'h00);
        o_wr.mask = mask8;
        o_wr.data = i_step[0] ? sh_data[15:8] : sh_data[7:0];
        o_addr    = AW'(page) * AW'(SCREEN_WIDTH) + AW'(x);
    end

endmodule

@@ rtl/text_glyph_page_framebuffer.sv @@
// top level of the page organized glyph framebuffer
// Takes one command word on s_axis (cmd in tuser, operands in tdata) and
// returns one result word on m_axis: the read byte and the cursor after
// the command. Commands run one at a time against a single ram of
// SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes with one read and one write port.
// Ram accesses per command:
//   set cursor and unused codes: none
//   plot: one read, one merged write; read: one read
//   draw char: ten byte read-modify-writes, reads overlapped with writes
//   clear: one zero write per byte
// After reset the ram is swept to zero, one byte per cycle (1024 bytes at
// the default size), and s_axis_tready stays low until the sweep ends.
// The result sits in an output register; the next command is accepted
// while it waits. If m_axis_tready stays low the block holds the finished
// command's result and does not accept another until it is taken.
module text_glyph_page_framebuffer import tgpf_pkg::*; #(
    parameter int SCREEN_WIDTH = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // pos_x, pos_y, pixel_on, char_code
    input  logic [2:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // read_byte, cursor_col, cursor_row
);

    localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;
    localparam int DEPTH = SCREEN_WIDTH * PAGES;
    localparam int AW = $clog2(DEPTH);

    t_state         r_state, n_state;
    logic [2:0]     r_cmd;
    logic           r_on;
    logic [7:0]     r_code;
    logic [AW-1:0]  r_addr;
    logic           r_pix_ok;
    logic [2:0]     r_bit;
    logic [3:0]     r_step;
    logic [AW-1:0]  r_cnt;
    logic           r_clr_cmd;
    logic [6:0]     r_cur_x;
    logic [7:0]     r_cur_y;
    logic [7:0]     r_rd_byte;
    logic [AW-1:0]  r_pend_addr;
    t_wr_req        r_pend_wr;
    logic           r_out_valid;
    logic [23:0]    r_out_data;

    logic           accept;
    logic [2:0]     in_cmd;
    logic [6:0]     in_x;
    logic [5:0]     in_y;
    logic           in_on;
    logic [7:0]     in_code;
    logic [AW-1:0]  in_addr;
    logic           in_ok;
    logic [AW-1:0]  g_addr;
    t_wr_req        g_wr;
    logic [AW-1:0]  ram_raddr;
    logic [AW-1:0]  ram_waddr;
    logic [7:0]     ram_rdata;
    logic [7:0]     ram_wdata;
    t_wr_req        wr;
    logic           out_free;
    logic [7:0]     n_x;
    logic [8:0]     n_y;
    logic           wrap;

    assign in_cmd  = s_axis_tuser;
    assign in_x    = s_axis_tdata[6:0];
    assign in_y    = s_axis_tdata[12:7];
    assign in_on   = s_axis_tdata[13];
    assign in_code = s_axis_tdata[21:14];
    assign accept  = s_axis_tvalid && s_axis_tready;
    assign in_addr = AW'(in_y[5:3]) * AW'(SCREEN_WIDTH) + AW'(in_x);
    assign in_ok   = ({2'b0, in_x} < 9'(SCREEN_WIDTH)) && ({3'b0, in_y} < 9'(SCREEN_HEIGHT));
    assign out_free = !r_out_valid || m_axis_tready;

    assign n_x  = {1'b0, r_cur_x} + ADVANCE_X;
    assign wrap = ({1'b0, n_x} > 9'(SCREEN_WIDTH - 5)) || (n_x > CURSOR_XMAX);
    assign n_y  = {1'b0, r_cur_y} + ADVANCE_Y;

    tgpf_glyph #(
        .SCREEN_WIDTH (SCREEN_WIDTH),
        .SCREEN_HEIGHT(SCREEN_HEIGHT)
    ) u_glyph (
        .i_step (r_step),
        .i_cur_x(r_cur_x),
        .i_cur_y(r_cur_y),
        .i_code (r_code),
        .o_addr (g_addr),
        .o_wr   (g_wr)
    );

    tgpf_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (wr.en),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign ram_wdata = (ram_rdata & ~wr.mask) | (wr.data & wr.mask);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_SWEEP: begin
                if (r_cnt == AW'(DEPTH - 1)) begin
                    n_state = r_clr_cmd ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (in_cmd)
                        CMD_CLEAR:           n_state = ST_SWEEP;
                        CMD_PLOT, CMD_READ:  n_state = ST_RD1;
                        CMD_DRAW:            n_state = ST_DRAW;
                        default:             n_state = ST_DONE;
                    endcase
                end
            end
            ST_RD1:  n_state = ST_RD2;
            ST_RD2:  n_state = ST_DONE;
            ST_DRAW: begin
                if (r_step == DRAW_STEPS) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        ram_raddr     = r_addr;
        ram_waddr     = r_pend_addr;
        wr            = '0;
        unique case (r_state)
            ST_SWEEP: begin
                ram_waddr = r_cnt;
                wr        = '{en: 1'b1, mask: 8'hFF, data: 8'h00};
            end
            ST_RD2: begin
                ram_waddr = r_addr;
                if (r_cmd == CMD_PLOT) begin
                    wr.en   = r_pix_ok;
                    wr.mask = 8'h01 << r_bit;
                    wr.data = r_on ? wr.mask : 8'h00;
                end
            end
            ST_DRAW: begin
                ram_raddr = g_addr;
                if (r_step != 4'd0) begin
                    wr = r_pend_wr;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_cnt       <= '0;
            r_clr_cmd   <= 1'b0;
            r_cur_x     <= '0;
            r_cur_y     <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_SWEEP) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (accept) begin
                r_cmd     <= in_cmd;
                r_on      <= in_on;
                r_code    <= in_code;
                r_addr    <= in_addr;
                r_pix_ok  <= in_ok;
                r_bit     <= in_y[2:0];
                r_step    <= '0;
                r_rd_byte <= '0;
                r_cnt     <= '0;
                r_clr_cmd <= (in_cmd == CMD_CLEAR);
                if (in_cmd == CMD_SET_CURSOR) begin
                    r_cur_x <= in_x;
                    r_cur_y <= {2'b0, in_y};
                end
            end
            if (r_state == ST_RD2 && r_cmd == CMD_READ) begin
                r_rd_byte <= r_pix_ok ? ram_rdata : 8'h00;
            end
            if (r_state == ST_DRAW) begin
                r_pend_addr <= g_addr;
                r_pend_wr   <= g_wr;
                if (r_step == DRAW_STEPS) begin
                    if (wrap) begin
                        r_cur_x <= '0;
                        r_cur_y <= (n_y > CURSOR_YMAX) ? 8'hFF : n_y[7:0];
                    end else begin
                        r_cur_x <= n_x[6:0];
                    end
                end else begin
                    r_step <= r_step + 1'b1;
                end
            end
            if (r_state == ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {1'b0, r_cur_y, r_cur_x, r_rd_byte};
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

@@ rtl/tgpf_checker.sv @@
// port level checks of the glyph framebuffer and their bind
`include "text_glyph_page_framebuffer_assert.svh"

module tgpf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // every command keeps the block busy in the cycle after it is accepted
    `TGPF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken in back to back cycles")

    `TGPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled output word changed")

    // a result only appears at the end of a command, never from idle
    `TGPF_ASSERT_SAME(a_out_from_busy, i_clk, i_rst_n, $rose(m_axis_tvalid), $past(!s_axis_tready), "output word raised while idle")

    // top bit of the output word is padding
    `TGPF_ASSERT_SAME(a_out_pad, i_clk, i_rst_n, m_axis_tvalid, !m_axis_tdata[23], "output pad bit set")

endmodule

bind text_glyph_page_framebuffer tgpf_checker u_tgpf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
);

@@ verif/tb_text_glyph_page_framebuffer.sv @@
// self-checking testbench for the glyph page framebuffer: command stream in, read byte and cursor out
module tb_text_glyph_page_framebuffer;
    import tgpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W    = 128;
    localparam int SCREEN_H    = 64;
    localparam int PAGE_BYTES  = SCREEN_W * ((SCREEN_H + 7) / 8);
    localparam int CELL_W      = 5;
    localparam int CELL_H      = 7;
    localparam int STEP_X      = 6;
    localparam int STEP_Y      = 9;
    localparam int COL_CAP     = 127;
    localparam int ROW_CAP     = 255;
    localparam int FIRST_GLYPH = 32;
    localparam int LAST_GLYPH  = 90;
    localparam int LOWER_A     = 97;
    localparam int LOWER_Z     = 122;
    localparam int CASE_SHIFT  = 32;
    localparam int QUIET_TAIL  = 150;
    localparam int TAIL_CYCLES = 40;

    localparam logic [2:0] CMD_RSVD_LO  = 3'd5;
    localparam logic [2:0] CMD_RSVD_MID = 3'd6;
    localparam logic [2:0] CMD_RSVD_HI  = 3'd7;

    // first column in the top byte, bit 0 is the top row of the cell
    localparam logic [39:0] FONT_COLS [0:58] = '{
        40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14,
        40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
        40'h001C224100, 40'h0041221C00, 40'h082A1C2A08, 40'h08083E0808,
        40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
        40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
        40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
        40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
        40'h0008142241, 40'h1414141414, 40'h4122140800, 40'h0201510906,
        40'h324979413E, 40'h7E1111117E, 40'h7F49494936, 40'h3E41414122,
        40'h7F4141221C, 40'h7F49494941, 40'h7F09090101, 40'h3E41415132,
        40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
        40'h7F40404040, 40'h7F0204027F, 40'h7F0408107F, 40'h3E4141413E,
        40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
        40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h7F2018207F,
        40'h6314081463, 40'h0304780403, 40'h6151494543
    };

    typedef struct packed {
        logic       hold_until_drained;
        logic [2:0] cmd;
        logic [6:0] pos_x;
        logic [5:0] pos_y;
        logic       pixel_on;
        logic [7:0] char_code;
    } t_glyph_cmd;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [6:0] col;
        logic [7:0] row;
    } t_fb_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // pos_x, pos_y, pixel_on, char_code
    logic [2:0]  s_axis_tuser = '0;  // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;       // read_byte, cursor_col, cursor_row

    t_glyph_cmd cmd_queue [$];
    t_fb_result pending_results [$];
    logic [7:0] shadow_fb [0:PAGE_BYTES-1];
    logic [6:0] shadow_col;
    logic [7:0] shadow_row;
    logic       cmd_taken = 1'b0;
    int         fail_count = 0;
    int         tx_gap = 0;
    int         rx_gap = 0;

    text_glyph_page_framebuffer #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- shadow framebuffer ----------------

    task automatic shadow_pixel(input int x, input int y, input logic on);
        int addr;
        if (x < SCREEN_W && y < SCREEN_H) begin
            addr = (y / 8) * SCREEN_W + x;
            shadow_fb[addr][y % 8] = on;
        end
    endtask

    task automatic shadow_command(input t_glyph_cmd c, output t_fb_result r);
        int         code;
        int         nx;
        int         ny;
        logic [7:0] column;
        r = '0;
        case (c.cmd)
            CMD_CLEAR: begin
                for (int i = 0; i < PAGE_BYTES; i++) shadow_fb[i] = '0;
            end
            CMD_PLOT: shadow_pixel(c.pos_x, c.pos_y, c.pixel_on);
            CMD_SET_CURSOR: begin
                shadow_col = c.pos_x;
                shadow_row = {2'b00, c.pos_y};
            end
            CMD_DRAW: begin
                code = c.char_code;
                if (code >= LOWER_A && code <= LOWER_Z) code -= CASE_SHIFT;
                if (code >= FIRST_GLYPH && code <= LAST_GLYPH) begin
                    for (int col = 0; col < CELL_W; col++) begin
                        column = FONT_COLS[code - FIRST_GLYPH][8*(CELL_W-1-col) +: 8];
                        for (int row = 0; row < CELL_H; row++)
                            shadow_pixel(shadow_col + col, shadow_row + row, column[row]);
                    end
                end
                nx = shadow_col + STEP_X;
                if (nx > SCREEN_W - 5 || nx > COL_CAP) begin
                    nx = 0;
                    ny = shadow_row + STEP_Y;
                    shadow_row = (ny > ROW_CAP) ? 8'(ROW_CAP) : 8'(ny);
                end
                shadow_col = 7'(nx);
            end
            CMD_READ: begin
                if (c.pos_x < SCREEN_W && c.pos_y < SCREEN_H)
                    r.read_byte = shadow_fb[(c.pos_y / 8) * SCREEN_W + c.pos_x];
            end
            default: ;
        endcase
        r.col = shadow_col;
        r.row = shadow_row;
    endtask

    // ---------------- stimulus ----------------

    task automatic push_cmd(input logic [2:0] cmd, input int x, input int y, input int on,
                            input int code, input logic drain);
        t_glyph_cmd c;
        c.hold_until_drained = drain;
        c.cmd       = cmd;
        c.pos_x     = 7'(x);
        c.pos_y     = 6'(y);
        c.pixel_on  = 1'(on);
        c.char_code = 8'(code);
        cmd_queue.push_back(c);
    endtask

    function automatic int pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6) return $urandom_range(FIRST_GLYPH, LAST_GLYPH);
        if (r < 8) return $urandom_range(LOWER_A, LOWER_Z);
        return $urandom_range(0, 255);
    endfunction

    task automatic push_text_run(input logic drain);
        int x0;
        int y0;
        x0 = $urandom_range(0, 127);
        y0 = $urandom_range(0, 63);
        push_cmd(CMD_SET_CURSOR, x0, y0, $urandom_range(0, 1), $urandom_range(0, 255), drain);
        repeat ($urandom_range(3, 20))
            push_cmd(CMD_DRAW, $urandom_range(0, 127), $urandom_range(0, 63),
                     $urandom_range(0, 1), pick_char(), 1'b0);
        repeat ($urandom_range(3, 10))
            push_cmd(CMD_READ, (x0 + $urandom_range(0, 60)) % 128,
                     (y0 + $urandom_range(0, 15)) % 64, $urandom_range(0, 1),
                     $urandom_range(0, 255), 1'b0);
    endtask

    task automatic push_plot_burst(input logic drain);
        int x0;
        int y0;
        x0 = $urandom_range(0, 119);
        y0 = $urandom_range(0, 47);
        repeat ($urandom_range(4, 16))
            push_cmd(CMD_PLOT, x0 + $urandom_range(0, 8), y0 + $urandom_range(0, 16),
                     $urandom_range(0, 3) != 0, $urandom_range(0, 255), drain);
        repeat ($urandom_range(3, 10))
            push_cmd(CMD_READ, x0 + $urandom_range(0, 8), y0 + $urandom_range(0, 16),
                     $urandom_range(0, 1), $urandom_range(0, 255), 1'b0);
    endtask

    task automatic build_directed();
        push_cmd(CMD_READ, 0, 0, 0, 0, 1'b0);
        push_cmd(CMD_PLOT, 0, 0, 1, 0, 1'b0);
        push_cmd(CMD_PLOT, 127, 63, 1, 8'hFF, 1'b0);
        push_cmd(CMD_READ, 0, 0, 1, 8'hFF, 1'b0);
        push_cmd(CMD_READ, 127, 63, 0, 0, 1'b0);
        push_cmd(CMD_PLOT, 127, 63, 0, 0, 1'b0);
        push_cmd(CMD_READ, 127, 63, 1, 0, 1'b0);
        // cell straddles pages 0 and 1
        push_cmd(CMD_SET_CURSOR, 0, 5, 0, 0, 1'b0);
        push_cmd(CMD_DRAW, 0, 0, 0, 8'h41, 1'b0);
        push_cmd(CMD_DRAW, 0, 0, 0, 8'h61, 1'b0);
        push_cmd(CMD_DRAW, 0, 0, 0, 8'h20, 1'b0);
        push_cmd(CMD_DRAW, 0, 0, 0, 8'h1F, 1'b0);
        push_cmd(CMD_DRAW, 0, 0, 0, 8'hFF, 1'b0);
        push_cmd(CMD_READ, 0, 0, 0, 0, 1'b0);
        push_cmd(CMD_READ, 6, 8, 0, 0, 1'b0);
        // clipped at the right and bottom edges, then wraps
        push_cmd(CMD_SET_CURSOR, 125, 60, 1, 0, 1'b0);
        push_cmd(CMD_DRAW, 0, 0, 0, 8'h23, 1'b0);
        push_cmd(CMD_READ, 125, 63, 0, 0, 1'b0);
        push_cmd(CMD_READ, 127, 56, 0, 0, 1'b0);
        push_cmd(CMD_SET_CURSOR, 117, 0, 0, 0, 1'b0);
        push_cmd(CMD_DRAW, 0, 0, 0, 8'h5A, 1'b0);
        push_cmd(CMD_DRAW, 0, 0, 0, 8'h7A, 1'b0);
        push_cmd(CMD_CLEAR, 127, 63, 1, 8'hFF, 1'b0);
        push_cmd(CMD_READ, 0, 0, 0, 0, 1'b0);
        push_cmd(CMD_RSVD_LO, 127, 63, 1, 8'hFF, 1'b0);
        push_cmd(CMD_RSVD_MID, 0, 0, 0, 0, 1'b0);
        push_cmd(CMD_RSVD_HI, 64, 32, 1, 8'h55, 1'b0);
    endtask

    task automatic build_random();
        int   pick;
        logic drain;
        logic flooded;
        flooded = 1'b0;
        while (cmd_queue.size() < 1250) begin
            pick  = $urandom_range(0, 99);
            drain = ($urandom_range(0, 19) == 0);
            if (!flooded && cmd_queue.size() > 500) begin
                // long unbroken text to drive the row into saturation
                flooded = 1'b1;
                push_cmd(CMD_SET_CURSOR, $urandom_range(0, 127), $urandom_range(48, 63),
                         $urandom_range(0, 1), $urandom_range(0, 255), 1'b1);
                repeat (470)
                    push_cmd(CMD_DRAW, $urandom_range(0, 127), $urandom_range(0, 63),
                             $urandom_range(0, 1), pick_char(), 1'b0);
                push_cmd(CMD_READ, $urandom_range(0, 127), $urandom_range(0, 63),
                         $urandom_range(0, 1), $urandom_range(0, 255), 1'b0);
            end else if (pick < 55) begin
                push_text_run(drain);
            end else if (pick < 75) begin
                push_plot_burst(drain);
            end else if (pick < 97) begin
                repeat ($urandom_range(1, 6))
                    push_cmd(3'($urandom_range(1, 7)), $urandom_range(0, 127),
                             $urandom_range(0, 63), $urandom_range(0, 1),
                             $urandom_range(0, 255), drain);
            end else begin
                push_cmd(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 63),
                         $urandom_range(0, 1), $urandom_range(0, 255), 1'b1);
            end
        end
    endtask

    // idling stops near the end, with quiet stretches along the way
    function automatic logic idling_allowed();
        return cmd_queue.size() > QUIET_TAIL && (cmd_queue.size() % 200) >= 40;
    endfunction

    // ---------------- command driver ----------------

    always @(negedge i_clk) begin
        t_glyph_cmd nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !cmd_taken) begin
            s_axis_tvalid <= 1'b1;
        end else if (tx_gap != 0) begin
            tx_gap = tx_gap - 1;
            s_axis_tvalid <= 1'b0;
        end else if (cmd_queue.size() == 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (cmd_queue[0].hold_until_drained && pending_results.size() != 0) begin
            s_axis_tvalid <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            tx_gap = $urandom_range(0, 5);
            s_axis_tvalid <= 1'b0;
        end else begin
            nxt = cmd_queue.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata  <= {2'b00, nxt.char_code, nxt.pixel_on, nxt.pos_y, nxt.pos_x};
            s_axis_tuser  <= nxt.cmd;
        end
    end

    // ---------------- result sink ----------------

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b1;
        end else if (rx_gap != 0) begin
            rx_gap = rx_gap - 1;
            m_axis_tready <= 1'b0;
        end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
            rx_gap = $urandom_range(0, 5);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ---------------- scoreboard ----------------

    task automatic report_field(input string name, input int want, input int seen);
        if (want != seen) begin
            fail_count++;
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, seen);
        end
    endtask

    always @(posedge i_clk) begin
        t_glyph_cmd acc;
        t_fb_result want;
        t_fb_result seen;
        cmd_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = {m_axis_tdata[7:0], m_axis_tdata[14:8], m_axis_tdata[22:15]};
            if (pending_results.size() == 0) begin
                fail_count++;
                $display("%0t ns: word with nothing expected, got %h", $time, m_axis_tdata);
            end else begin
                want = pending_results.pop_front();
                report_field("read_byte", want.read_byte, seen.read_byte);
                report_field("cursor_col", want.col, seen.col);
                report_field("cursor_row", want.row, seen.row);
            end
        end
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            acc.hold_until_drained = 1'b0;
            acc.cmd       = s_axis_tuser;
            acc.pos_x     = s_axis_tdata[6:0];
            acc.pos_y     = s_axis_tdata[12:7];
            acc.pixel_on  = s_axis_tdata[13];
            acc.char_code = s_axis_tdata[21:14];
            shadow_command(acc, want);
            pending_results.push_back(want);
        end
    end

    // ---------------- run control ----------------

    initial begin
        for (int i = 0; i < PAGE_BYTES; i++) shadow_fb[i] = '0;
        shadow_col = '0;
        shadow_row = '0;
        build_directed();
        build_random();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        while (cmd_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
